@@ rtl/cbwn_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Blend-weight normalizer package
// Shared sequencer states, the NDF fixed-point format and the status bundle
// exported by the divider.
// ----------------------------------------------------------------------------
package cbwn_pkg;

  // Fraction bits of the NDF and weight words; the 17-bit ports hold 1.0.
  localparam int FRACTION_BITS = 16;

  // Sequencer states of the top level.
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SUM_RD,
    ST_SUM,
    ST_W_RD,
    ST_W_R,
    ST_W_A,
    ST_W_B,
    ST_W_MUL,
    ST_N_RD,
    ST_N_DIV,
    ST_EMIT
  } cbwn_state_t;

  // Handshake between the sequencer and the shared divider.
  typedef struct packed {
    logic busy;
    logic done;
  } cbwn_div_stat_t;

endpackage
`default_nettype wire

@@ rtl/cbwn_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Shared restoring divider
// Computes num / den one quotient bit per cycle; a zero divisor yields zero.
// ----------------------------------------------------------------------------
module cbwn_div #(
  parameter int NumW = 56,
  parameter int DenW = 40
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [NumW-1:0] num,
  input  wire logic [DenW-1:0] den,
  output cbwn_pkg::cbwn_div_stat_t stat,
  output      logic [NumW-1:0] quo
);
  import cbwn_pkg::*;

  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] q_r, q_nxt;
  logic [DenW:0]   rem_r, rem_nxt;
  logic [DenW-1:0] den_r, den_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [DenW:0]   trial;

  // One restoring step per cycle, numerator bits enter from the top.
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DenW-1:0], q_r[NumW-1]};
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CntW'(NumW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[NumW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[NumW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Zero divisor gives quotient zero (all-ones otherwise from the loop).
  assign quo  = (den_r == '0) ? '0 : q_r;
  assign stat = '{busy: busy_r, done: done_r};

endmodule
`default_nettype wire

@@ rtl/cubemap_blend_weight_normalizer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Cubemap blend-weight normalizer
// Stores per-volume NDF words and emits normalized blend weights per set.
// ----------------------------------------------------------------------------
// Words are taken one per cycle while a set loads. The word marked last starts
// the compute phase, during which in_ready is low. A set of N > 1 volumes
// runs a sum pass, a weight pass (three 64-step divisions per volume plus
// read, start and multiply) and a normalization pass (one 64-step division per
// weight plus read and hand-off), all serialized on the single shared
// bit-serial divider and the one-read-port NDF/weight memories; a single
// volume skips the weight and normalization passes. Each weight is then handed
// out as one word through a registered output, and output stalls add directly
// to the set's time.
module cubemap_blend_weight_normalizer #(
  parameter int MAX_VOLUMES   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [16:0] in_ndf_value,
  input  wire logic        in_last_item,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [16:0] out_blend_weight,
  output      logic [3:0]  out_volume_index,
  output      logic        out_last_result,
  output      logic        out_overflowed
);
  import cbwn_pkg::*;

  localparam int IdxW  = $clog2(MAX_VOLUMES);
  localparam int CntW  = $clog2(MAX_VOLUMES + 1);
  localparam int SumW  = 17 + CntW;
  localparam int NumW  = 64;
  localparam int DenW  = 40;
  localparam logic [16:0] OneIn = 17'(1 << FRACTION_BITS);

  // Memories: clamped NDFs, then raw weights of the current set.
  logic [16:0] ndf_mem [MAX_VOLUMES];
  logic [33:0] w_mem   [MAX_VOLUMES];
  logic [16:0] ndf_rd_r;
  logic [33:0] w_rd_r;

  cbwn_state_t state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [CntW-1:0] ptr_r, ptr_nxt;
  logic            ovf_r, ovf_nxt;
  logic [SumW-1:0] s_r, s_nxt, t_r, t_nxt;
  logic [DenW-1:0] wsum_r, wsum_nxt;
  logic [32:0]     r_r, r_nxt;
  logic [32:0]     a_r, a_nxt;
  logic [66:0]     prod;
  logic [16:0]     ndf_clamp;
  logic            div_start;
  logic [NumW-1:0] div_num;
  logic [DenW-1:0] div_den;
  cbwn_div_stat_t  dstat;
  logic [NumW-1:0] div_q;
  logic            w_we;
  logic [33:0]     w_wd;
  logic            out_load;
  logic [16:0]     ob_nxt;

  logic [IdxW-1:0] rd_idx;
  logic            ld_we;

  assign ndf_clamp = (in_ndf_value > OneIn) ? OneIn : in_ndf_value;
  assign in_ready  = (state_r == ST_LOAD);
  assign ld_we     = in_valid && in_ready && (cnt_r < CntW'(MAX_VOLUMES));
  assign rd_idx    = ptr_r[IdxW-1:0];

  // Memory ports: one write and one registered read each.
  always_ff @(posedge clk) begin
    if (ld_we) ndf_mem[cnt_r[IdxW-1:0]] <= ndf_clamp;
    ndf_rd_r <= ndf_mem[rd_idx];
    if (w_we) w_mem[rd_idx] <= w_wd;
    w_rd_r <= w_mem[rd_idx];
  end

  cbwn_div #(.NumW(NumW), .DenW(DenW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
    .den(div_den), .stat(dstat), .quo(div_q)
  );

  // Full a * b; both factors reach 2^32, so the product needs 65 bits.
  assign prod = {34'b0, a_r} * {33'b0, div_q[33:0]};

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ptr_nxt   = ptr_r;
    ovf_nxt   = ovf_r;
    s_nxt     = s_r;
    t_nxt     = t_r;
    wsum_nxt  = wsum_r;
    r_nxt     = r_r;
    a_nxt     = a_r;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    w_we      = 1'b0;
    w_wd      = prod[65:32];
    out_load  = 1'b0;
    ob_nxt    = div_q[16:0];
    unique case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          if (cnt_r < CntW'(MAX_VOLUMES)) cnt_nxt = cnt_r + 1'b1;
          else ovf_nxt = 1'b1;
          if (in_last_item) begin
            ptr_nxt = '0;
            s_nxt = '0;
            t_nxt = '0;
            wsum_nxt = '0;
            state_nxt = ST_SUM_RD;
          end
        end
      end
      ST_SUM_RD: state_nxt = ST_SUM;
      ST_SUM: begin
        s_nxt = s_r + SumW'(ndf_rd_r);
        t_nxt = t_r + SumW'(OneIn - ndf_rd_r);
        if (ptr_r + 1'b1 == cnt_r) begin
          ptr_nxt = '0;
          state_nxt = (cnt_r == CntW'(1)) ? ST_EMIT : ST_W_RD;
          if (cnt_r == CntW'(1)) out_load = 1'b1;
          ob_nxt = OneIn;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
          state_nxt = ST_SUM_RD;
        end
      end
      ST_W_RD: state_nxt = ST_W_R;
      ST_W_R: begin
        // r = ndf << 32 / S
        if (!dstat.busy && !dstat.done) begin
          div_start = 1'b1;
          div_num = NumW'({ndf_rd_r, 32'b0});
          div_den = DenW'(s_r);
        end else if (dstat.done) begin
          r_nxt = div_q[32:0];
          state_nxt = ST_W_A;
          div_start = 1'b1;
          div_num = NumW'(33'h1_0000_0000 - div_q[32:0]);
          div_den = DenW'(cnt_r - 1'b1);
        end
      end
      ST_W_A: begin
        if (dstat.done) begin
          a_nxt = div_q[32:0];
          state_nxt = ST_W_B;
          div_start = 1'b1;
          div_num = NumW'({OneIn - ndf_rd_r, 32'b0});
          div_den = DenW'(t_r);
        end
      end
      ST_W_B: if (dstat.done) state_nxt = ST_W_MUL;
      ST_W_MUL: begin
        w_we = 1'b1;
        wsum_nxt = wsum_r + DenW'(prod[65:32]);
        if (ptr_r + 1'b1 == cnt_r) begin
          ptr_nxt = '0;
          state_nxt = ST_N_RD;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
          state_nxt = ST_W_RD;
        end
      end
      ST_N_RD: begin
        if (wsum_r == '0) wsum_nxt = DenW'(64'h1_0000_0000);
        state_nxt = ST_N_DIV;
      end
      ST_N_DIV: begin
        if (!dstat.busy && !dstat.done) begin
          div_start = 1'b1;
          div_num = NumW'({w_rd_r, FRACTION_BITS'(0)});
          div_den = wsum_r;
        end else if (dstat.done) begin
          out_load = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          if (ptr_r + 1'b1 >= cnt_r) begin
            cnt_nxt = '0;
            ovf_nxt = 1'b0;
            ptr_nxt = '0;
            state_nxt = ST_LOAD;
          end else begin
            ptr_nxt = ptr_r + 1'b1;
            state_nxt = ST_N_RD;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    s_r    <= s_nxt;
    t_r    <= t_nxt;
    wsum_r <= wsum_nxt;
    r_r    <= r_nxt;
    a_r    <= a_nxt;
    if (out_load) begin
      out_blend_weight <= ob_nxt;
      out_volume_index <= 4'(ptr_r);
      out_last_result  <= (ptr_r + 1'b1 == cnt_r);
      out_overflowed   <= ovf_r;
    end
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      ptr_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ptr_r   <= ptr_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  assign out_valid = (state_r == ST_EMIT);

  // The loaded count never passes capacity.
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MAX_VOLUMES)) else $error("count above capacity");
  // Results only appear for a non-empty set.
  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != '0) else $error("emit with empty set");
  // Input is never taken while the divider is busy.
  a_no_load: assert property (@(posedge clk) disable iff (!rst_n)
    dstat.busy |-> !in_ready) else $error("input open while dividing");

endmodule
`default_nettype wire
